FILE: hdl/vn3_pkg.sv
// Shared constants for the 3D vector normalizer.
// No dependencies; used by vn3_scale and vector_normalize_3d.
`timescale 1ns / 1ps
package vn3_pkg;
  localparam int INPUT_WIDTH_DEF   = 32;
  localparam int OUT_FRAC_BITS_DEF = 30;
  localparam int UNIT_W            = 32;  // width of one result component
endpackage

FILE: hdl/vector_normalize_3d.sv
// Top level of the 3D vector normalizer: magnitude, squares, length^2, three lanes.
// Depends on vn3_pkg and vn3_scale.
//
//  channel   | direction | tdata (low bit up)              | tuser
//  in_       | slave     | comp_x, comp_y, comp_z          | -
//  out_      | master    | unit_x, unit_y, unit_z          | zero_length
//
// One word enters per cycle while the output is not stalled; each lane resolves one quotient bit
// and one root digit per stage.
// rst_n clears valid bits only; payload registers are not reset.
// A stalled output word freezes the whole pipeline; nothing is dropped or repeated.
`timescale 1ns / 1ps
module vector_normalize_3d #(
  parameter int INPUT_WIDTH   = vn3_pkg::INPUT_WIDTH_DEF,
  parameter int OUT_FRAC_BITS = vn3_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((3*INPUT_WIDTH+7)/8)*8-1:0]    in_tdata,  // comp_x, comp_y, comp_z
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [3*vn3_pkg::UNIT_W-1:0]          out_tdata, // unit_x, unit_y, unit_z
  output logic                                  out_tuser  // zero_length
);
  localparam int W    = INPUT_WIDTH;
  localparam int UW   = vn3_pkg::UNIT_W;
  localparam int LO   = (W + 1) / 2;
  localparam int HI   = W - LO;
  localparam int SW   = 2*W + 2;
  localparam int LLAT = (2*OUT_FRAC_BITS + 1) + (OUT_FRAC_BITS + 1);

  logic en;
  logic out_valid_r;
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // stage 1: magnitudes
  logic         v1_r;
  logic [W-1:0] mag1_r [3];
  logic         neg1_r [3];
  // stage 2: partial products
  logic              v2_r;
  logic [2*HI-1:0]   hh2_r [3];
  logic [HI+LO-1:0]  hl2_r [3];
  logic [2*LO-1:0]   ll2_r [3];
  logic              neg2_r [3];
  // stage 3: squares
  logic           v3_r;
  logic [2*W-1:0] sq3_r [3];
  logic           neg3_r [3];
  // stage 4: length^2
  logic           v4_r;
  logic [SW-1:0]  s4_r;
  logic           zero4_r;
  logic [2*W-1:0] sq4_r [3];
  logic           neg4_r [3];

  logic v_chain_r [LLAT];
  logic z_chain_r [LLAT];

  logic [UW-1:0] lane_unit [3];
  logic [UW-1:0] unit_r [3];
  logic          zero_r;

  for (genvar c = 0; c < 3; c++) begin : g_comp
    logic [W-1:0] raw;
    assign raw = in_tdata[c*W +: W];
    always_ff @(posedge clk) begin
      if (en) begin
        neg1_r[c] <= raw[W-1];
        mag1_r[c] <= raw[W-1] ? (W'(0) - raw) : raw;
        hh2_r[c]  <= (2*HI)'(mag1_r[c][W-1 -: HI]) * (2*HI)'(mag1_r[c][W-1 -: HI]);
        hl2_r[c]  <= (HI+LO)'(mag1_r[c][W-1 -: HI]) * (HI+LO)'(mag1_r[c][LO-1:0]);
        ll2_r[c]  <= (2*LO)'(mag1_r[c][LO-1:0]) * (2*LO)'(mag1_r[c][LO-1:0]);
        neg2_r[c] <= neg1_r[c];
        sq3_r[c]  <= ((2*W)'(hh2_r[c]) << (2*LO)) + ((2*W)'(hl2_r[c]) << (LO+1))
                   + (2*W)'(ll2_r[c]);
        neg3_r[c] <= neg2_r[c];
        sq4_r[c]  <= sq3_r[c];
        neg4_r[c] <= neg3_r[c];
      end
    end

    vn3_scale #(
      .INPUT_WIDTH   (INPUT_WIDTH),
      .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_scale (
      .clk    (clk),
      .en     (en),
      .mag2_i (sq4_r[c]),
      .s_i    (s4_r),
      .neg_i  (neg4_r[c]),
      .unit_o (lane_unit[c])
    );

    always_ff @(posedge clk) begin
      if (en) begin
        unit_r[c] <= z_chain_r[LLAT-1] ? '0 : lane_unit[c];
      end
    end
    assign out_tdata[c*UW +: UW] = unit_r[c];
  end

  logic [SW-1:0] s_nxt;
  assign s_nxt = SW'(sq3_r[0]) + SW'(sq3_r[1]) + SW'(sq3_r[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      s4_r    <= s_nxt;
      zero4_r <= (s_nxt == '0);
      zero_r  <= z_chain_r[LLAT-1];
      for (int i = 0; i < LLAT; i++) begin
        z_chain_r[i] <= (i == 0) ? zero4_r : z_chain_r[(i == 0) ? 0 : i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < LLAT; i++) begin
        v_chain_r[i] <= 1'b0;
      end
    end else if (en) begin
      v1_r        <= in_tvalid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      out_valid_r <= v_chain_r[LLAT-1];
      for (int i = 0; i < LLAT; i++) begin
        v_chain_r[i] <= (i == 0) ? v4_r : v_chain_r[(i == 0) ? 0 : i-1];
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = zero_r;

  // a zero-length word carries an all-zero vector
  a_zero_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == '0))
    else $error("zero_length word with nonzero components");

  // no non-negative component exceeds unit magnitude
  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((unit_r[0][UW-1] || unit_r[0] <= UW'(1) << OUT_FRAC_BITS) &&
                    (unit_r[1][UW-1] || unit_r[1] <= UW'(1) << OUT_FRAC_BITS) &&
                    (unit_r[2][UW-1] || unit_r[2] <= UW'(1) << OUT_FRAC_BITS)))
    else $error("unit component out of range");

  // the pipeline freezes while the output word is stalled
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> ($stable(v4_r) && $stable(s4_r)))
    else $error("pipeline moved during output stall");
endmodule

FILE: hdl/vn3_scale.sv
// One component lane: restoring divide of mag^2 * 2^(2F) by s, then integer sqrt.
// One bit of quotient and one root digit per register stage. Depends on vn3_pkg.
`timescale 1ns / 1ps
module vn3_scale #(
  parameter int INPUT_WIDTH   = vn3_pkg::INPUT_WIDTH_DEF,
  parameter int OUT_FRAC_BITS = vn3_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic [2*INPUT_WIDTH-1:0]       mag2_i,
  input  logic [2*INPUT_WIDTH+1:0]       s_i,
  input  logic                           neg_i,
  output logic [vn3_pkg::UNIT_W-1:0]     unit_o
);
  localparam int SW   = 2*INPUT_WIDTH + 2;
  localparam int RW   = SW + 1;
  localparam int QW   = 2*OUT_FRAC_BITS + 1;
  localparam int NDIV = QW;
  localparam int NSQ  = OUT_FRAC_BITS + 1;
  localparam int RADW = 2*NSQ;
  localparam int SRW  = OUT_FRAC_BITS + 4;
  localparam int RTW  = OUT_FRAC_BITS + 1;
  localparam int UW   = vn3_pkg::UNIT_W;

  logic [RW-1:0] drem_r  [NDIV];
  logic [QW-1:0] dquot_r [NDIV];
  logic [SW-1:0] ds_r    [NDIV];
  logic          dneg_r  [NDIV];

  logic [RADW-1:0] srad_r  [NSQ];
  logic [SRW-1:0]  srem_r  [NSQ];
  logic [RTW-1:0]  sroot_r [NSQ];
  logic            sneg_r  [NSQ];

  // divider: stage 0 takes mag^2 unshifted, later stages shift in one bit each
  for (genvar k = 0; k < NDIV; k++) begin : g_div
    localparam int KP = (k == 0) ? 0 : k - 1;
    logic [RW-1:0] rem_sh;
    logic [QW-1:0] quot_sh;
    logic [SW-1:0] s_in;
    logic          neg_in;
    logic          ge;
    logic [RW-1:0] rem_nxt;
    logic [QW-1:0] quot_nxt;
    always_comb begin
      if (k == 0) begin
        rem_sh  = RW'(mag2_i);
        quot_sh = '0;
        s_in    = s_i;
        neg_in  = neg_i;
      end else begin
        rem_sh  = drem_r[KP] << 1;
        quot_sh = dquot_r[KP] << 1;
        s_in    = ds_r[KP];
        neg_in  = dneg_r[KP];
      end
      ge       = (rem_sh >= RW'(s_in));
      rem_nxt  = ge ? (rem_sh - RW'(s_in)) : rem_sh;
      quot_nxt = quot_sh | QW'(ge);
    end
    always_ff @(posedge clk) begin
      if (en) begin
        drem_r[k]  <= rem_nxt;
        dquot_r[k] <= quot_nxt;
        ds_r[k]    <= s_in;
        dneg_r[k]  <= neg_in;
      end
    end
  end

  // digit-by-digit square root, two radicand bits per stage
  for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
    localparam int JP = (j == 0) ? 0 : j - 1;
    logic [RADW-1:0] rad_in;
    logic [SRW-1:0]  rem_in;
    logic [RTW-1:0]  root_in;
    logic            neg_in;
    logic [SRW-1:0]  r2;
    logic [SRW-1:0]  trial;
    logic            ge;
    logic [SRW-1:0]  rem_nxt;
    logic [RTW-1:0]  root_nxt;
    always_comb begin
      if (j == 0) begin
        rad_in  = RADW'(dquot_r[NDIV-1]);
        rem_in  = '0;
        root_in = '0;
        neg_in  = dneg_r[NDIV-1];
      end else begin
        rad_in  = srad_r[JP];
        rem_in  = srem_r[JP];
        root_in = sroot_r[JP];
        neg_in  = sneg_r[JP];
      end
      r2       = {rem_in[SRW-3:0], rad_in[RADW-1 -: 2]};
      trial    = {1'b0, root_in, 2'b01};
      ge       = (r2 >= trial);
      rem_nxt  = ge ? (r2 - trial) : r2;
      root_nxt = {root_in[RTW-2:0], ge};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        srad_r[j]  <= rad_in << 2;
        srem_r[j]  <= rem_nxt;
        sroot_r[j] <= root_nxt;
        sneg_r[j]  <= neg_in;
      end
    end
  end

  logic [UW-1:0] root_ext;
  assign root_ext = UW'(sroot_r[NSQ-1]);
  assign unit_o   = sneg_r[NSQ-1] ? (UW'(0) - root_ext) : root_ext;
endmodule

FILE: verif/vector_normalize_3d_tb.sv
// Testbench for vector_normalize_3d: drives Q16.16 vectors, checks Q2.30 unit vectors.
// Depends on vn3_pkg and the vector_normalize_3d RTL; predicts results with exact integer math.
`timescale 1ns / 1ps
module vector_normalize_3d_tb;

  localparam int IW = vn3_pkg::INPUT_WIDTH_DEF;
  localparam int FB = vn3_pkg::OUT_FRAC_BITS_DEF;
  localparam int UNIT_W = vn3_pkg::UNIT_W;
  localparam int DW = ((3*IW+7)/8)*8;
  localparam int LATENCY = 4 + (2*FB+1) + (FB+1) + 1;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [IW-1:0] z;
    logic [IW-1:0] y;
    logic [IW-1:0] x;
  } vec_t;

  typedef struct packed {
    logic [UNIT_W-1:0] ux;
    logic [UNIT_W-1:0] uy;
    logic [UNIT_W-1:0] uz;
    logic              zlen;
  } unit_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [DW-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [3*UNIT_W-1:0] out_tdata;
  logic out_tuser;

  vec_t pending_vecs[$];
  unit_t expected_units[$];
  int errors = 0;
  int in_gap = 0;
  int out_gap = 0;
  int hold_off = 0;
  int accepted = 0;
  bit hold_done = 0;
  bit stim_done = 0;
  longint cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  vector_normalize_3d i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  // floor(sqrt(v)) by bit-wise digit recurrence
  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // sign(c) * floor(|c| * 2^FB / sqrt(s)) via floor(sqrt(floor(c^2 * 2^2FB / s)))
  function automatic logic [UNIT_W-1:0] scale_lane(logic [IW-1:0] raw, logic [127:0] len_sq);
    logic neg;
    logic [IW:0] mag;
    logic [255:0] num;
    logic [255:0] q;
    logic [63:0] root;
    neg = raw[IW-1];
    mag = neg ? ({1'b0, ~raw} + 1'b1) : {1'b0, raw};
    num = ({192'd0, 64'(mag)} * {192'd0, 64'(mag)}) << (2*FB);
    q = num / {128'd0, len_sq};
    root = int_sqrt(q[63:0]);
    return neg ? UNIT_W'(-root) : UNIT_W'(root);
  endfunction

  function automatic unit_t normalize(vec_t v);
    unit_t r;
    logic [127:0] len_sq;
    logic [IW:0] m[3];
    logic [IW-1:0] c[3];
    c = '{v.x, v.y, v.z};
    len_sq = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = c[i][IW-1] ? ({1'b0, ~c[i]} + 1'b1) : {1'b0, c[i]};
      len_sq += 128'(m[i]) * 128'(m[i]);
    end
    if (len_sq == 0) begin
      r = '{ux: '0, uy: '0, uz: '0, zlen: 1'b1};
    end else begin
      r.ux = scale_lane(v.x, len_sq);
      r.uy = scale_lane(v.y, len_sq);
      r.uz = scale_lane(v.z, len_sq);
      r.zlen = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [IW-1:0] rand_comp();
    case ($urandom_range(0, 7))
      0: return IW'(32'h8000_0000);
      1: return IW'(32'h7fff_ffff);
      2: return '0;
      3: return IW'($signed($urandom_range(0, 64)) - 32);
      4: return IW'($urandom) >> $urandom_range(0, IW-1);
      default: return IW'($urandom);
    endcase
  endfunction

  task automatic add_vec(logic [IW-1:0] x, logic [IW-1:0] y, logic [IW-1:0] z);
    pending_vecs.push_back('{z: z, y: y, x: x});
  endtask

  initial begin
    logic [IW-1:0] mn, mx;
    mn = IW'(32'h8000_0000);
    mx = IW'(32'h7fff_ffff);
    // zero vector, axis-aligned, most negative, mixed extremes
    add_vec(0, 0, 0);
    add_vec(32'h0001_0000, 0, 0);
    add_vec(0, -32'sd1, 0);
    add_vec(0, 0, mn);
    add_vec(mn, 0, 0);
    add_vec(0, mx, 0);
    add_vec(mn, mn, mn);
    add_vec(mx, mx, mx);
    add_vec(mn, mx, mn);
    add_vec(1, 1, 1);
    add_vec(-32'sd1, 1, -32'sd1);
    add_vec(3, 4, 0);
    add_vec(mx, 1, 0);
    add_vec(mn, 0, 1);
    add_vec(32'hffff_ffff, 32'h5555_5555, 32'haaaa_aaaa);
    add_vec(0, 0, 1);
    for (int i = 0; i < 1600; i++) add_vec(rand_comp(), rand_comp(), rand_comp());
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  // driver: hold the word until taken, then pause a random gap
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_units.push_back(normalize(vec_t'(in_tdata[3*IW-1:0])));
        accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_tvalid <= 1'b0;
        end else if (pending_vecs.size() > 0) begin
          in_tdata <= DW'(pending_vecs.pop_front());
          in_tvalid <= 1'b1;
          in_gap <= (accepted % 400 < 200) ? 0 : $urandom_range(0, 10);
        end else begin
          in_tvalid <= 1'b0;
          stim_done <= 1'b1;
        end
      end
    end
  end

  // receiver stall: one long hold-off early in the run, plus random gaps
  always @(posedge clk) begin
    if (rst_n) begin
      if (!hold_done && accepted >= 40) begin
        hold_done <= 1'b1;
        hold_off <= 400;
      end else if (hold_off > 0) begin
        hold_off <= hold_off - 1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    unit_t got, want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = '{ux: out_tdata[3*UNIT_W-1:2*UNIT_W], uy: out_tdata[2*UNIT_W-1:UNIT_W],
                uz: out_tdata[UNIT_W-1:0], zlen: out_tuser};
        // tdata packs x in the low bits
        got.ux = out_tdata[UNIT_W-1:0];
        got.uz = out_tdata[3*UNIT_W-1:2*UNIT_W];
        if (expected_units.size() == 0) begin
          $display("%0t: unexpected word exp none act %h/%h/%h/%b", $time,
                   got.ux, got.uy, got.uz, got.zlen);
          errors++;
        end else begin
          want = expected_units.pop_front();
          if (got.ux !== want.ux) begin
            $display("%0t: unit_x exp %h act %h", $time, want.ux, got.ux);
            errors++;
          end
          if (got.uy !== want.uy) begin
            $display("%0t: unit_y exp %h act %h", $time, want.uy, got.uy);
            errors++;
          end
          if (got.uz !== want.uz) begin
            $display("%0t: unit_z exp %h act %h", $time, want.uz, got.uz);
            errors++;
          end
          if (got.zlen !== want.zlen) begin
            $display("%0t: zero_length exp %b act %b", $time, want.zlen, got.zlen);
            errors++;
          end
        end
      end
      if (hold_off > 1 || (!hold_done && accepted >= 40)) begin
        out_tready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (out_tvalid && out_tready)
          out_gap <= (accepted % 500 < 250) ? 0 : $urandom_range(0, 10);
      end
    end
  end

  initial begin
    wait (rst_n);
    while (!(stim_done && expected_units.size() == 0) && cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
    end else begin
      repeat (LATENCY + 20) @(posedge clk);
      if (errors == 0) begin
        $display("tb: success");
      end else begin
        $display("tb: failure");
      end
    end
    $finish;
  end
endmodule
